// ===== rtl/core/obb_pkg.sv =====
`default_nettype none

package obb_pkg;

	// width of one multiplier digit in the shared unit
	localparam int DIGIT_W = 16;

	// one step of the per-axis schedule, in issue order
	typedef enum logic [3:0] {
		OP_TX  = 4'd0,
		OP_TY  = 4'd1,
		OP_RX1 = 4'd2,
		OP_RY1 = 4'd3,
		OP_UX1 = 4'd4,
		OP_UY1 = 4'd5,
		OP_RX2 = 4'd6,
		OP_RY2 = 4'd7,
		OP_UX2 = 4'd8,
		OP_UY2 = 4'd9,
		OP_HX1 = 4'd10,
		OP_HY1 = 4'd11,
		OP_HX2 = 4'd12,
		OP_HY2 = 4'd13
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_OUT   = 4'b1000
	} seq_state_t;

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_MUL  = 3'b010,
		M_ACC  = 3'b100
	} mac_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/obb_in_if.sv =====
`default_nettype none

interface obb_in_if #(
	parameter int COORD_WIDTH    = 32,
	parameter int AXIS_FRAC_BITS = 14
);
	localparam int AXIS_W = AXIS_FRAC_BITS + 2;

	logic                          valid;
	logic                          ready;
	logic                          which_box;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic        [COORD_WIDTH-2:0] half_width;
	logic        [COORD_WIDTH-2:0] half_height;
	logic signed [AXIS_W-1:0]      right_x;
	logic signed [AXIS_W-1:0]      right_y;
	logic signed [AXIS_W-1:0]      up_x;
	logic signed [AXIS_W-1:0]      up_y;

	modport source (
		output valid, which_box, center_x, center_y, half_width, half_height,
		output right_x, right_y, up_x, up_y,
		input  ready
	);
	modport sink (
		input  valid, which_box, center_x, center_y, half_width, half_height,
		input  right_x, right_y, up_x, up_y,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/obb_out_if.sv =====
`default_nettype none

interface obb_out_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink (input valid, overlap, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/obb_mac.sv =====
`default_nettype none

module obb_mac #(
	parameter int OA_W = 33,
	parameter int OB_W = 33
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     clear,
	input  wire logic signed [OA_W-1:0]   op_a,
	input  wire logic signed [OB_W-1:0]   op_b,
	output logic                          busy,
	output logic                          done,
	output logic signed [OA_W+((OB_W+obb_pkg::DIGIT_W-1)/obb_pkg::DIGIT_W)*obb_pkg::DIGIT_W+1:0] acc
);
	import obb_pkg::*;

	localparam int ND    = (OB_W + DIGIT_W - 1) / DIGIT_W;
	localparam int BS_W  = ND * DIGIT_W;
	localparam int PW    = OA_W + BS_W;
	localparam int ACC_W = PW + 2;
	localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;

	mac_state_t              st_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic [OA_W-1:0]         a_q;
	logic [BS_W-1:0]         bsh_q;
	logic                    neg_q;
	logic                    clr_q;
	logic [PW-1:0]           prod_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [OA_W-1:0]         a_mag;
	logic [OB_W-1:0]         b_mag;
	logic [DIGIT_W-1:0]      digit;
	logic [OA_W+DIGIT_W-1:0] pp;
	logic signed [ACC_W-1:0] term;

	// magnitudes and sign of the product
	assign a_mag = op_a[OA_W-1] ? OA_W'(-op_a) : OA_W'(op_a);
	assign b_mag = op_b[OB_W-1] ? OB_W'(-op_b) : OB_W'(op_b);
	assign digit = bsh_q[BS_W-1 -: DIGIT_W];
	assign pp    = a_q * digit;
	assign term  = neg_q ? -ACC_W'(prod_q) : ACC_W'(prod_q);

	// sequence: load, one digit a cycle from the top, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (start) begin
						st_q  <= M_MUL;
						cnt_q <= '0;
					end
				end
				M_MUL: begin
					if (cnt_q == CNT_W'(ND - 1)) st_q <= M_ACC;
					else cnt_q <= cnt_q + 1'b1;
				end
				M_ACC: begin
					st_q   <= M_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	// operand, product and accumulator registers
	always_ff @(posedge clk) begin
		if (st_q == M_IDLE && start) begin
			a_q    <= a_mag;
			bsh_q  <= BS_W'(b_mag);
			neg_q  <= op_a[OA_W-1] ^ op_b[OB_W-1];
			clr_q  <= clear;
			prod_q <= '0;
		end
		if (st_q == M_MUL) begin
			bsh_q  <= bsh_q << DIGIT_W;
			prod_q <= (prod_q << DIGIT_W) + PW'(pp);
		end
		if (st_q == M_ACC) begin
			acc_q <= (clr_q ? '0 : acc_q) + term;
		end
	end

	assign busy = (st_q != M_IDLE);
	assign done = done_q;
	assign acc  = acc_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != M_IDLE) |-> !start) else $error("start while busy");
	a_done_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == M_ACC) |=> done_q) else $error("missing done");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");

endmodule

`default_nettype wire

// ===== rtl/core/obb_overlap_test_2d.sv =====
`default_nettype none

// Separating axis test for two oriented 2D boxes. Send the first box with
// which_box low: it is stored and gives no result. Send the second box with
// which_box high: it is tested against the stored box and one overlap bit
// comes back (touching boxes overlap). A test runs on one shared
// multiply-accumulate unit that takes a 16-bit digit of its second operand
// per cycle, and each of the four axes takes fourteen multiplications,
// issued one after another. A test stops at the first axis that separates
// the boxes. The input is not ready while a test runs or its result waits.
module obb_overlap_test_2d #(
	parameter int COORD_WIDTH    = 32,
	parameter int AXIS_FRAC_BITS = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	obb_in_if.sink   box,
	obb_out_if.source result
);
	import obb_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int AW    = AXIS_FRAC_BITS + 2;
	localparam int OA_W  = (CW + 1 > AW) ? CW + 1 : AW;
	localparam int OB_W  = 2 * AW + 1;
	localparam int ND    = (OB_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PW    = OA_W + ND * DIGIT_W;
	localparam int ACC_W = PW + 2;
	localparam int CMP_W = ACC_W + AXIS_FRAC_BITS;

	seq_state_t state_q;
	op_t        op_q;
	logic [1:0] ax_q;
	logic       overlap_q;

	// stored box
	logic signed [CW-1:0] s_cx_q, s_cy_q;
	logic        [CW-2:0] s_hx_q, s_hy_q;
	logic signed [AW-1:0] s_rx_q, s_ry_q, s_ux_q, s_uy_q;
	// box under test
	logic signed [CW-1:0] c_cx_q, c_cy_q;
	logic        [CW-2:0] c_hx_q, c_hy_q;
	logic signed [AW-1:0] c_rx_q, c_ry_q, c_ux_q, c_uy_q;
	// per-axis partial results
	logic [ACC_W-1:0]       lhs_q;
	logic signed [OB_W-1:0] d0_q, d1_q, d2_q, d3_q;

	logic signed [CW:0]      tx, ty;
	logic signed [AW-1:0]    lx, ly;
	logic signed [OA_W-1:0]  op_a;
	logic signed [OB_W-1:0]  op_b;
	logic                    mac_start, mac_clear, mac_busy, mac_done;
	logic signed [ACC_W-1:0] mac_acc;
	logic [ACC_W-1:0]        acc_mag;
	logic                    sep;
	logic                    in_acc;

	assign in_acc = box.valid && box.ready;
	assign tx = {c_cx_q[CW-1], c_cx_q} - {s_cx_q[CW-1], s_cx_q};
	assign ty = {c_cy_q[CW-1], c_cy_q} - {s_cy_q[CW-1], s_cy_q};

	// pick the axis under trial
	always_comb begin
		case (ax_q)
			2'd0:    begin lx = s_rx_q; ly = s_ry_q; end
			2'd1:    begin lx = s_ux_q; ly = s_uy_q; end
			2'd2:    begin lx = c_rx_q; ly = c_ry_q; end
			default: begin lx = c_ux_q; ly = c_uy_q; end
		endcase
	end

	// operands of the current step
	always_comb begin
		case (op_q)
			OP_TX:   begin op_a = OA_W'(tx);     op_b = OB_W'(lx); end
			OP_TY:   begin op_a = OA_W'(ty);     op_b = OB_W'(ly); end
			OP_RX1:  begin op_a = OA_W'(s_rx_q); op_b = OB_W'(lx); end
			OP_RY1:  begin op_a = OA_W'(s_ry_q); op_b = OB_W'(ly); end
			OP_UX1:  begin op_a = OA_W'(s_ux_q); op_b = OB_W'(lx); end
			OP_UY1:  begin op_a = OA_W'(s_uy_q); op_b = OB_W'(ly); end
			OP_RX2:  begin op_a = OA_W'(c_rx_q); op_b = OB_W'(lx); end
			OP_RY2:  begin op_a = OA_W'(c_ry_q); op_b = OB_W'(ly); end
			OP_UX2:  begin op_a = OA_W'(c_ux_q); op_b = OB_W'(lx); end
			OP_UY2:  begin op_a = OA_W'(c_uy_q); op_b = OB_W'(ly); end
			OP_HX1:  begin op_a = OA_W'(s_hx_q); op_b = d0_q; end
			OP_HY1:  begin op_a = OA_W'(s_hy_q); op_b = d1_q; end
			OP_HX2:  begin op_a = OA_W'(c_hx_q); op_b = d2_q; end
			OP_HY2:  begin op_a = OA_W'(c_hy_q); op_b = d3_q; end
			default: begin op_a = '0;            op_b = '0; end
		endcase
	end

	assign mac_start = (state_q == S_ISSUE);
	assign mac_clear = op_q inside {OP_TX, OP_RX1, OP_UX1, OP_RX2, OP_UX2, OP_HX1};

	obb_mac #(
		.OA_W (OA_W),
		.OB_W (OB_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.clear  (mac_clear),
		.op_a   (op_a),
		.op_b   (op_b),
		.busy   (mac_busy),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	assign acc_mag = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
	// separated when the scaled centre distance exceeds the sum of both radii
	assign sep = (CMP_W'(lhs_q) << AXIS_FRAC_BITS) > CMP_W'($unsigned(mac_acc));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_TX;
			ax_q      <= 2'd0;
			overlap_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && box.which_box) begin
						state_q <= S_ISSUE;
						op_q    <= OP_TX;
						ax_q    <= 2'd0;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (mac_done) begin
						if (op_q == OP_HY2) begin
							if (sep || ax_q == 2'd3) begin
								overlap_q <= !sep;
								state_q   <= S_OUT;
							end else begin
								ax_q    <= ax_q + 2'd1;
								op_q    <= OP_TX;
								state_q <= S_ISSUE;
							end
						end else begin
							op_q    <= op_t'(op_q + 4'd1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_OUT: begin
					if (result.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the stored box, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_cx_q <= '0; s_cy_q <= '0; s_hx_q <= '0; s_hy_q <= '0;
			s_rx_q <= '0; s_ry_q <= '0; s_ux_q <= '0; s_uy_q <= '0;
		end else if (in_acc && !box.which_box) begin
			s_cx_q <= box.center_x;   s_cy_q <= box.center_y;
			s_hx_q <= box.half_width; s_hy_q <= box.half_height;
			s_rx_q <= box.right_x;    s_ry_q <= box.right_y;
			s_ux_q <= box.up_x;       s_uy_q <= box.up_y;
		end
	end

	// capture the box under test and keep partial results
	always_ff @(posedge clk) begin
		if (in_acc && box.which_box) begin
			c_cx_q <= box.center_x;   c_cy_q <= box.center_y;
			c_hx_q <= box.half_width; c_hy_q <= box.half_height;
			c_rx_q <= box.right_x;    c_ry_q <= box.right_y;
			c_ux_q <= box.up_x;       c_uy_q <= box.up_y;
		end
		if (state_q == S_WAIT && mac_done) begin
			case (op_q)
				OP_TY:   lhs_q <= acc_mag;
				OP_RY1:  d0_q  <= OB_W'(acc_mag);
				OP_UY1:  d1_q  <= OB_W'(acc_mag);
				OP_RY2:  d2_q  <= OB_W'(acc_mag);
				OP_UY2:  d3_q  <= OB_W'(acc_mag);
				default: ;
			endcase
		end
	end

	assign box.ready      = (state_q == S_IDLE);
	assign result.valid   = (state_q == S_OUT);
	assign result.overlap = overlap_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mac_start |-> !mac_busy) else $error("issue to busy unit");
	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && box.which_box) |=> (state_q == S_ISSUE && op_q == OP_TX))
		else $error("test did not start");
	a_store_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !box.which_box) |=> !result.valid) else $error("result on store");

endmodule

`default_nettype wire

// ===== dv/obb_overlap_checker.sv =====
`default_nettype none

module obb_overlap_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	obb_in_if         box,
	obb_out_if        result,
	output int        errors,
	output int        pending,
	output int        tests,
	output int        hits
);

	typedef logic signed [127:0] wide_t;

	// copy of the first box as the block holds it
	wide_t held_cx, held_cy, held_hx, held_hy;
	wide_t held_rx, held_ry, held_ux, held_uy;

	// expected overlap bits, oldest first
	bit overlap_due[$];

	function automatic wide_t mag(wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	// radius of a box projected on the axis (lx, ly)
	function automatic wide_t reach(wide_t hx, wide_t hy, wide_t rx, wide_t ry,
			wide_t ux, wide_t uy, wide_t lx, wide_t ly);
		return hx * mag(rx * lx + ry * ly) + hy * mag(ux * lx + uy * ly);
	endfunction

	function automatic bit boxes_overlap(wide_t cx, wide_t cy, wide_t hx, wide_t hy,
			wide_t rx, wide_t ry, wide_t ux, wide_t uy);
		wide_t tx, ty, lx, ly, lhs, rhs;
		tx = cx - held_cx;
		ty = cy - held_cy;
		for (int i = 0; i < 4; i++) begin
			case (i)
				0: begin lx = held_rx; ly = held_ry; end
				1: begin lx = held_ux; ly = held_uy; end
				2: begin lx = rx; ly = ry; end
				default: begin lx = ux; ly = uy; end
			endcase
			lhs = mag(tx * lx + ty * ly) <<< 14;
			rhs = reach(held_hx, held_hy, held_rx, held_ry, held_ux, held_uy, lx, ly)
				+ reach(hx, hy, rx, ry, ux, uy, lx, ly);
			// strict compare: touching boxes still overlap
			if (lhs > rhs)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// predict on each accepted box item, compare each accepted result item
	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			held_cx <= '0; held_cy <= '0; held_hx <= '0; held_hy <= '0;
			held_rx <= '0; held_ry <= '0; held_ux <= '0; held_uy <= '0;
			errors <= 0;
			tests <= 0;
			hits <= 0;
			pending <= 0;
			overlap_due.delete();
		end else begin
			if (box.valid && box.ready) begin
				if (!box.which_box) begin
					held_cx <= wide_t'(box.center_x);
					held_cy <= wide_t'(box.center_y);
					held_hx <= wide_t'(box.half_width);
					held_hy <= wide_t'(box.half_height);
					held_rx <= wide_t'(box.right_x);
					held_ry <= wide_t'(box.right_y);
					held_ux <= wide_t'(box.up_x);
					held_uy <= wide_t'(box.up_y);
				end else begin
					want = boxes_overlap(wide_t'(box.center_x), wide_t'(box.center_y),
						wide_t'(box.half_width), wide_t'(box.half_height),
						wide_t'(box.right_x), wide_t'(box.right_y),
						wide_t'(box.up_x), wide_t'(box.up_y));
					overlap_due = {overlap_due, want};
					tests <= tests + 1;
					hits <= hits + want;
				end
			end
			if (result.valid && result.ready) begin
				if (overlap_due.size() == 0) begin
					$display("%0t: unexpected result item, overlap %0b", $time,
						result.overlap);
					errors <= errors + 1;
				end else begin
					want = overlap_due.pop_front();
					if (result.overlap !== want) begin
						$display("%0t: overlap mismatch, expected %0b actual %0b", $time,
							want, result.overlap);
						errors <= errors + 1;
					end
				end
			end
			pending <= overlap_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/obb_overlap_test_2d_test.sv =====
`default_nettype none

module obb_overlap_test_2d_test;

	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1950;

	typedef struct {
		bit               which;
		logic signed [31:0] cx, cy;
		logic [30:0]      hx, hy;
		logic signed [15:0] rx, ry, ux, uy;
	} box_t;

	logic clk;
	logic arst_n;
	int   errors, pending, tests, hits;
	int   sent;
	int   idle_cycles;

	obb_in_if  box ();
	obb_out_if result ();

	obb_overlap_test_2d dut (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box.sink),
		.result (result.source)
	);

	obb_overlap_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.box     (box),
		.result  (result),
		.errors  (errors),
		.pending (pending),
		.tests   (tests),
		.hits    (hits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		box.valid = 1'b0; box.which_box = 1'b0;
		box.center_x = '0; box.center_y = '0;
		box.half_width = '0; box.half_height = '0;
		box.right_x = '0; box.right_y = '0; box.up_x = '0; box.up_y = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// count cycles with no accepted item, give up at the limit
	always @(posedge clk) begin
		if (!arst_n || (box.valid && box.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: random stall before each result item
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 12);
			if ($urandom_range(0, 3) == 0)
				stall = 0;
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
		end
	end

	task automatic send_box(box_t b, int gap);
		if (gap > 0) begin
			box.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box.valid <= 1'b1;
		box.which_box <= b.which;
		box.center_x <= b.cx; box.center_y <= b.cy;
		box.half_width <= b.hx; box.half_height <= b.hy;
		box.right_x <= b.rx; box.right_y <= b.ry;
		box.up_x <= b.ux; box.up_y <= b.uy;
		@(posedge clk);
		while (!box.ready) @(posedge clk);
		sent++;
	endtask

	function automatic box_t make_box(bit which, logic signed [31:0] cx, logic signed [31:0] cy,
			logic [30:0] hx, logic [30:0] hy, logic signed [15:0] rx, logic signed [15:0] ry,
			logic signed [15:0] ux, logic signed [15:0] uy);
		box_t b;
		b.which = which; b.cx = cx; b.cy = cy; b.hx = hx; b.hy = hy;
		b.rx = rx; b.ry = ry; b.ux = ux; b.uy = uy;
		return b;
	endfunction

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return '0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// mostly boxes near each other so both verdicts come up, some full-range noise
	function automatic box_t rand_box(bit which);
		box_t b;
		logic signed [15:0] a, c;
		b.which = which;
		if ($urandom_range(0, 7) == 0) begin
			b.cx = $urandom; b.cy = $urandom;
			b.hx = 31'($urandom); b.hy = 31'($urandom);
			b.rx = rand_axis(); b.ry = rand_axis(); b.ux = rand_axis(); b.uy = rand_axis();
		end else begin
			b.cx = $signed($urandom_range(0, 524288)) - 262144;
			b.cy = $signed($urandom_range(0, 524288)) - 262144;
			b.hx = 31'($urandom_range(0, 131072));
			b.hy = 31'($urandom_range(0, 131072));
			if ($urandom_range(0, 2) == 0) begin
				b.rx = rand_axis(); b.ry = rand_axis(); b.ux = rand_axis(); b.uy = rand_axis();
			end else begin
				// rotated frame: up is right turned a quarter
				a = rand_axis();
				c = rand_axis();
				b.rx = a; b.ry = c; b.ux = -c; b.uy = a;
			end
		end
		return b;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 4) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	initial begin
		sent = 0;
		@(posedge arst_n);
		@(posedge clk);

		// test before any store, against the reset point box
		send_box(make_box(1, 32'sd65536, 0, 31'd65536, 31'd65536,
			16'sd16384, 0, 0, 16'sd16384), 0);
		send_box(make_box(1, 0, 0, 0, 0, 0, 0, 0, 0), rand_gap());
		// touching boxes overlap
		send_box(make_box(0, 0, 0, 31'd65536, 31'd65536, 16'sd16384, 0, 0, 16'sd16384), 3);
		send_box(make_box(1, 32'sd131072, 0, 31'd65536, 31'd65536,
			16'sd16384, 0, 0, 16'sd16384), 0);
		send_box(make_box(1, 32'sd131073, 0, 31'd65536, 31'd65536,
			16'sd16384, 0, 0, 16'sd16384), 0);
		// extremes of centres, sizes and axis codes
		send_box(make_box(0, 32'h7fffffff, 32'h80000000, 31'h7fffffff, 0,
			-16'sd32768, 16'sd32767, -16'sd16384, 16'sd16384), 2);
		send_box(make_box(1, 32'h80000000, 32'h7fffffff, 0, 31'h7fffffff,
			-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767), 0);
		send_box(make_box(1, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
			-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768), 1);
		send_box(make_box(0, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 31'h7fffffff,
			16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767), 0);
		send_box(make_box(1, 32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
			-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768), 0);
		send_box(make_box(1, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 0), 0);
		// zero axes on a stored box
		send_box(make_box(0, 32'sd1000, -32'sd1000, 31'd5000, 31'd5000, 0, 0, 0, 0), 0);
		send_box(make_box(1, 0, 0, 31'd100, 31'd100, 16'sd16384, 0, 0, 16'sd16384), 0);
		send_box(make_box(1, 32'sd900000, 0, 31'd100, 31'd100, 0, 0, 0, 0), 0);
		// rotated by 45 degrees, Q1.14
		send_box(make_box(0, 0, 0, 31'd65536, 31'd65536,
			16'sd11585, 16'sd11585, -16'sd11585, 16'sd11585), 0);
		send_box(make_box(1, 32'sd150000, 32'sd150000, 31'd65536, 31'd65536,
			16'sd16384, 0, 0, 16'sd16384), 0);
		send_box(make_box(1, 32'sd100000, 32'sd100000, 31'd65536, 31'd65536,
			16'sd16384, 0, 0, 16'sd16384), 0);

		// random part: store then test mostly, with repeats and stray stores
		for (int n = 0; n < RANDOM_ITEMS; ) begin
			if (n > RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 3) begin
				// let every outstanding result drain before going on
				box.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0: begin send_box(rand_box(0), rand_gap()); n++; end
				1, 2: begin send_box(rand_box(1), rand_gap()); n++; end
				default: begin
					send_box(rand_box(0), rand_gap());
					send_box(rand_box(1), rand_gap());
					n += 2;
				end
			endcase
		end
		box.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("%0d box items sent, %0d pair tests checked, %0d overlapping", sent,
			tests, hits);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
